### sv/isfe_pkg.sv
// Shared types, widths and command codes for the Ising spin-flip engine.
// Used by the controller, the datapath and the top level; no dependencies.
package isfe_pkg;

    localparam int SITE_W   = 10;
    localparam int SLOT_W   = 13;
    localparam int RANGE_W  = 14;
    localparam int ENERGY_W = 24;
    localparam int COUNT_W  = 32;
    localparam int CMD_W    = 3;
    localparam int SUM_W    = RANGE_W + 1;
    localparam int DELTA_W  = SUM_W + 1;
    localparam int TRIAL_W  = ENERGY_W + 1;

    localparam int MAX_SITES = 2 ** SITE_W;
    localparam int MAX_SLOTS = 2 ** SLOT_W;

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 64;

    localparam logic [CMD_W-1:0] CMD_WR_SPIN   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_NEIGH  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_RANGE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_ENRGY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRIAL     = 3'd4;

    localparam logic [RANGE_W-1:0] SLOT_LIMIT = RANGE_W'(MAX_SLOTS);

    typedef logic signed [ENERGY_W-1:0] t_energy;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [DELTA_W-1:0]  t_delta;
    typedef logic signed [TRIAL_W-1:0]  t_trial;

    localparam t_energy E_MAX = 24'sh7FFFFF;
    localparam t_energy E_MIN = 24'sh800000;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic latch;
        logic scan_en;
        logic eval;
        logic load_out;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             scan_done;
    } t_dp_status;

endpackage

### sv/ising_spin_flip_energy_cap_top.sv
// Top level of the Ising single-spin-flip engine with energy ceiling: stream ports,
// beat unpacking and output packing; uses isfe_pkg, isfe_ctrl, isfe_dp.
// A trial runs the neighbor scan, one slot per cycle, between latch and evaluate; other
// commands go from execute and latch straight to loading the result.
// Throughput: one beat in flight; the next input is taken the cycle after the result loads.
// Reset: synchronous active low; clears energy, count, ceiling and control, not the memories.
module ising_spin_flip_energy_cap_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [isfe_pkg::ENERGY_W-1:0]      i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // site[9:0], spin_down[10], slot[23:11], neighbor_site[33:24],
    // range_first[47:34], range_stop[61:48], energy_value[85:62], zeros[87:86]
    input  logic [isfe_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd[2:0], zeros[7:3]
    input  logic [isfe_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accepted[0], energy[24:1], accept_total[56:25], spin_now[57], zeros[63:58]
    output logic [isfe_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    isfe_pkg::t_ctl_cmd               cmd;
    isfe_pkg::t_dp_status             status;
    logic                             accepted;
    logic [isfe_pkg::ENERGY_W-1:0]    energy;
    logic [isfe_pkg::COUNT_W-1:0]     accept_total;
    logic                             spin_now;

    isfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    isfe_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd_code      (s_axis_tuser[2:0]),
        .i_site          (s_axis_tdata[9:0]),
        .i_spin_down     (s_axis_tdata[10]),
        .i_slot          (s_axis_tdata[23:11]),
        .i_neighbor_site (s_axis_tdata[33:24]),
        .i_range_first   (s_axis_tdata[47:34]),
        .i_range_stop    (s_axis_tdata[61:48]),
        .i_energy_value  (s_axis_tdata[85:62]),
        .o_accepted      (accepted),
        .o_energy        (energy),
        .o_accept_total  (accept_total),
        .o_spin_now      (spin_now)
    );

    assign m_axis_tdata = {6'd0, spin_now, accept_total, energy, accepted};

endmodule

### sv/isfe_ctrl.sv
// Sequencer for the spin-flip engine: steps each item through execute and latch,
// a trial also through neighbor scan and evaluate, and owns the output valid. Uses isfe_pkg.
module isfe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  isfe_pkg::t_dp_status  i_status,
    output isfe_pkg::t_ctl_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LATCH,
        S_SCAN,
        S_EVAL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load_out;

    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  n_state = S_LATCH;
            S_LATCH: begin
                if (i_status.cmd == isfe_pkg::CMD_TRIAL) n_state = S_SCAN;
                else n_state = S_DONE;
            end
            S_SCAN:  if (i_status.scan_done) n_state = S_EVAL;
            S_EVAL:  n_state = S_DONE;
            S_DONE:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.latch    = (r_state == S_LATCH);
        o_cmd.scan_en  = (r_state == S_SCAN);
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.load_out = load_out;
    end

endmodule

### sv/isfe_dp.sv
// Datapath of the spin-flip engine: spin, neighbor and range memories,
// the pipelined neighbor-sum scan, energy and accept count. Uses isfe_pkg.
module isfe_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  isfe_pkg::t_ctl_cmd                     i_cmd,
    output isfe_pkg::t_dp_status                   o_status,
    input  logic                                   i_cfg_wr_en,
    input  logic [isfe_pkg::ENERGY_W-1:0]          i_cfg_wr_data,
    input  logic [isfe_pkg::CMD_W-1:0]             i_cmd_code,
    input  logic [isfe_pkg::SITE_W-1:0]            i_site,
    input  logic                                   i_spin_down,
    input  logic [isfe_pkg::SLOT_W-1:0]            i_slot,
    input  logic [isfe_pkg::SITE_W-1:0]            i_neighbor_site,
    input  logic [isfe_pkg::RANGE_W-1:0]           i_range_first,
    input  logic [isfe_pkg::RANGE_W-1:0]           i_range_stop,
    input  logic [isfe_pkg::ENERGY_W-1:0]          i_energy_value,
    output logic                                   o_accepted,
    output logic [isfe_pkg::ENERGY_W-1:0]          o_energy,
    output logic [isfe_pkg::COUNT_W-1:0]           o_accept_total,
    output logic                                   o_spin_now
);

    // memories
    logic                             spin_mem [isfe_pkg::MAX_SITES];
    logic [isfe_pkg::SITE_W-1:0]      nb_mem   [isfe_pkg::MAX_SLOTS];
    logic [2*isfe_pkg::RANGE_W-1:0]   rng_mem  [isfe_pkg::MAX_SITES];

    // captured item
    logic [isfe_pkg::CMD_W-1:0]       r_cmd;
    logic [isfe_pkg::SITE_W-1:0]      r_site;
    logic                             r_down;
    logic [isfe_pkg::SLOT_W-1:0]      r_slot;
    logic [isfe_pkg::SITE_W-1:0]      r_nsite;
    logic [isfe_pkg::RANGE_W-1:0]     r_rfirst;
    logic [isfe_pkg::RANGE_W-1:0]     r_rstop;
    isfe_pkg::t_energy                r_evalue;

    isfe_pkg::t_energy                r_ceiling;
    isfe_pkg::t_energy                r_energy;
    logic [isfe_pkg::COUNT_W-1:0]     r_count;

    logic                             r_spin_q;
    logic [isfe_pkg::SITE_W-1:0]      r_nb_q;
    logic [2*isfe_pkg::RANGE_W-1:0]   r_rng_q;

    logic                             r_own;
    logic                             r_acc;
    logic [isfe_pkg::RANGE_W-1:0]     r_ptr;
    logic [isfe_pkg::RANGE_W-1:0]     r_stop;
    logic                             r_v1, r_v2;
    isfe_pkg::t_sum                   r_sum;

    logic                             r_o_acc;
    isfe_pkg::t_energy                r_o_energy;
    logic [isfe_pkg::COUNT_W-1:0]     r_o_count;
    logic                             r_o_spin;

    logic                             issue;
    logic [isfe_pkg::SITE_W-1:0]      spin_rd_addr;
    logic                             spin_we;
    logic                             spin_wd;
    logic [isfe_pkg::RANGE_W-1:0]     stop_clamped;
    isfe_pkg::t_delta                 sum2;
    isfe_pkg::t_delta                 delta;
    isfe_pkg::t_trial                 trial;
    logic                             flip_ok;
    isfe_pkg::t_energy                energy_sat;

    assign issue        = i_cmd.scan_en && (r_ptr < r_stop);
    assign spin_rd_addr = r_v1 ? r_nb_q : r_site;
    assign stop_clamped = (r_rng_q[2*isfe_pkg::RANGE_W-1:isfe_pkg::RANGE_W]
                           > isfe_pkg::SLOT_LIMIT)
                        ? isfe_pkg::SLOT_LIMIT
                        : r_rng_q[2*isfe_pkg::RANGE_W-1:isfe_pkg::RANGE_W];

    assign sum2  = {r_sum, 1'b0};
    assign delta = r_own ? -sum2 : sum2;
    assign trial = isfe_pkg::t_trial'(r_energy) + isfe_pkg::t_trial'(delta);
    assign flip_ok = (trial <= isfe_pkg::t_trial'(r_ceiling));

    always_comb begin
        if (trial > isfe_pkg::t_trial'(isfe_pkg::E_MAX)) begin
            energy_sat = isfe_pkg::E_MAX;
        end else if (trial < isfe_pkg::t_trial'(isfe_pkg::E_MIN)) begin
            energy_sat = isfe_pkg::E_MIN;
        end else begin
            energy_sat = isfe_pkg::t_energy'(trial);
        end
    end

    always_comb begin
        spin_we = 1'b0;
        spin_wd = r_down;
        if (i_cmd.exec && r_cmd == isfe_pkg::CMD_WR_SPIN) begin
            spin_we = 1'b1;
        end else if (i_cmd.eval && flip_ok) begin
            spin_we = 1'b1;
            spin_wd = ~r_own;
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (spin_we) begin
            spin_mem[r_site] <= spin_wd;
        end
        r_spin_q <= spin_mem[spin_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_cmd == isfe_pkg::CMD_WR_NEIGH) begin
            nb_mem[r_slot] <= r_nsite;
        end
        r_nb_q <= nb_mem[r_ptr[isfe_pkg::SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_cmd == isfe_pkg::CMD_WR_RANGE) begin
            rng_mem[r_site] <= {r_rstop, r_rfirst};
        end
        r_rng_q <= rng_mem[r_site];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_site   <= i_site;
            r_down   <= i_spin_down;
            r_slot   <= i_slot;
            r_nsite  <= i_neighbor_site;
            r_rfirst <= i_range_first;
            r_rstop  <= i_range_stop;
            r_evalue <= isfe_pkg::t_energy'(i_energy_value);
        end
        if (i_cmd.latch) begin
            // a spin write's read returned the old value
            r_own  <= (r_cmd == isfe_pkg::CMD_WR_SPIN) ? r_down : r_spin_q;
            r_ptr  <= r_rng_q[isfe_pkg::RANGE_W-1:0];
            r_stop <= stop_clamped;
            r_sum  <= '0;
        end else begin
            if (issue) begin
                r_ptr <= r_ptr + isfe_pkg::RANGE_W'(1);
            end
            if (r_v2) begin
                r_sum <= r_spin_q ? r_sum - isfe_pkg::SUM_W'(1)
                                  : r_sum + isfe_pkg::SUM_W'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_o_acc    <= r_acc;
            r_o_energy <= r_energy;
            r_o_count  <= r_count;
            r_o_spin   <= r_own ^ r_acc;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd     <= isfe_pkg::CMD_WR_SPIN;
            r_ceiling <= '0;
            r_energy  <= '0;
            r_count   <= '0;
            r_acc     <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_cmd <= i_cmd_code;
            end
            if (i_cfg_wr_en) begin
                r_ceiling <= isfe_pkg::t_energy'(i_cfg_wr_data);
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (i_cmd.latch) begin
                r_acc <= 1'b0;
            end
            if (i_cmd.exec && r_cmd == isfe_pkg::CMD_SET_ENRGY) begin
                r_energy <= r_evalue;
                r_count  <= '0;
            end
            if (i_cmd.eval && flip_ok) begin
                r_energy <= energy_sat;
                r_acc    <= 1'b1;
                if (r_count != '1) begin
                    r_count <= r_count + isfe_pkg::COUNT_W'(1);
                end
            end
        end
    end

    assign o_status.cmd       = r_cmd;
    assign o_status.scan_done = !(r_ptr < r_stop) && !r_v1 && !r_v2;

    assign o_accepted     = r_o_acc;
    assign o_energy       = r_o_energy;
    assign o_accept_total = r_o_count;
    assign o_spin_now     = r_o_spin;

    // spin data is summed only in the cycle after its address came out of the slot read
    a_scan_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("scan stage 2 without stage 1");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count))
        |-> (r_count == $past(r_count) + isfe_pkg::COUNT_W'(1)) || (r_count == '0))
        else $error("accept count moved by other than one");

    a_flip_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_acc) |-> r_energy <= $past(r_ceiling))
        else $error("accepted flip above energy ceiling");

endmodule
